FILE: design/erfe_pkg.sv
// shared constants, types and per-term tables for the erf approximation pipeline
`default_nettype none

package erfe_pkg;

   // fixed-point constants
   localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
   localparam logic [31:0] LN2_Q32     = 32'd2977044472;
   localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
   localparam logic [31:0] A_LOG2E_Q30 = 32'd3067182370;
   localparam logic [31:0] B_Q30       = 32'd2160084138;
   localparam logic [20:0] ONE_Q20     = 21'h10_0000;
   localparam logic [15:0] Y_MAX       = 16'd16384;

   // pipeline geometry
   localparam int SERIES_TERMS = 12;
   localparam int EXP_LATENCY  = 2 * SERIES_TERMS + 2;
   localparam int U_W          = 31;
   localparam int NUM_W        = 33;
   localparam int DEN_W        = 47;
   localparam int DIV_BITS     = 21;
   localparam int DIV_STAGES   = DIV_BITS + 1;
   localparam int REM_W        = 69;
   localparam int K_MAX        = 32;

   // per-item data that travels with the series terms
   typedef struct packed {
      logic [31:0] z;
      logic [5:0]  k;
      logic        zero;
   } exp_carry_type;

   // reciprocal multiplier for an exact floor(p / n), p below 2^32
   function automatic logic [32:0] term_magic(input logic [3:0] n);
      logic [32:0] m;
      case (n)
         4'd1:    m = 33'd4294967296;
         4'd2:    m = 33'd4294967296;
         4'd3:    m = 33'd5726623062;
         4'd4:    m = 33'd4294967296;
         4'd5:    m = 33'd6871947674;
         4'd6:    m = 33'd5726623062;
         4'd7:    m = 33'd4908534053;
         4'd8:    m = 33'd4294967296;
         4'd9:    m = 33'd7635497416;
         4'd10:   m = 33'd6871947674;
         4'd11:   m = 33'd6247225158;
         4'd12:   m = 33'd5726623062;
         default: m = 33'd4294967296;
      endcase
      return m;
   endfunction

   // right shift that goes with term_magic
   function automatic logic [5:0] term_shift(input logic [3:0] n);
      logic [5:0] s;
      case (n)
         4'd1:    s = 6'd32;
         4'd2:    s = 6'd33;
         4'd3:    s = 6'd34;
         4'd4:    s = 6'd34;
         4'd5:    s = 6'd35;
         4'd6:    s = 6'd35;
         4'd7:    s = 6'd35;
         4'd8:    s = 6'd35;
         4'd9:    s = 6'd36;
         4'd10:   s = 6'd36;
         4'd11:   s = 6'd36;
         4'd12:   s = 6'd36;
         default: s = 6'd32;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: design/erfe_exp_term.sv
// one series term of exp(-z): r_out = 1 - floor(floor(z*r)/n), two register stages
`default_nettype none

module erfe_exp_term (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic [3:0]             term_index,
   input  wire logic                   valid_in,
   input  wire logic [32:0]            r_in,
   input  wire erfe_pkg::exp_carry_type carry_in,
   output logic                        valid_out,
   output logic [32:0]                 r_out,
   output erfe_pkg::exp_carry_type     carry_out
);
   import erfe_pkg::*;

   logic          va_ff, vb_ff;
   logic [31:0]   p_ff, p_in;
   logic [31:0]   qt_ff, qt_in;
   exp_carry_type ca_ff, cb_ff;
   logic [63:0]   zr_prod;
   logic [64:0]   mq_prod;

   // z * r, with r = 1.0 taken as a plain pass of z
   always_comb begin
      zr_prod = carry_in.z * r_in[31:0];
      p_in    = r_in[32] ? carry_in.z : zr_prod[63:32];
   end

   // floor(p / n) by reciprocal multiply
   always_comb begin
      mq_prod = {33'b0, p_ff} * {32'b0, term_magic(term_index)};
      qt_in   = 32'(mq_prod >> term_shift(term_index));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (enable) begin
         va_ff <= valid_in;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff  <= p_in;
         ca_ff <= carry_in;
         qt_ff <= qt_in;
         cb_ff <= ca_ff;
      end
   end

   assign valid_out = vb_ff;
   assign r_out     = ONE_Q32 - {1'b0, qt_ff};
   assign carry_out = cb_ff;

endmodule

`default_nettype wire

FILE: design/erfe_neg_exp.sv
// exp(-t) in Q32 from a Q24 base-2 exponent: split, series chain, final shift
`default_nettype none

module erfe_neg_exp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enable,
   input  wire logic                    valid_in,
   input  wire logic [erfe_pkg::U_W-1:0] u_value,
   output logic                         valid_out,
   output logic [32:0]                  exp_value
);
   import erfe_pkg::*;

   logic          v0_ff;
   exp_carry_type c0_ff, c0_in;
   logic [6:0]    k_full;
   logic [63:0]   z_prod;

   logic          tv   [SERIES_TERMS+1];
   logic [32:0]   tr   [SERIES_TERMS+1];
   exp_carry_type tc   [SERIES_TERMS+1];

   logic          ve_ff;
   logic [32:0]   e_ff, e_in;

   // integer / fraction split and fraction times ln 2
   always_comb begin
      k_full     = u_value[U_W-1:24];
      z_prod     = {u_value[23:0], 8'b0} * LN2_Q32;
      c0_in.z    = z_prod[63:32];
      c0_in.zero = (k_full > 7'(K_MAX));
      c0_in.k    = k_full[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         c0_ff <= c0_in;
      end
   end

   assign tv[0] = v0_ff;
   assign tr[0] = ONE_Q32;
   assign tc[0] = c0_ff;

   // terms n = 12 down to 1
   for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_term
      erfe_exp_term u_term (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .term_index (4'(SERIES_TERMS - i)),
         .valid_in   (tv[i]),
         .r_in       (tr[i]),
         .carry_in   (tc[i]),
         .valid_out  (tv[i+1]),
         .r_out      (tr[i+1]),
         .carry_out  (tc[i+1])
      );
   end

   // scale by 2^-k, underflow to zero
   always_comb begin
      e_in = tc[SERIES_TERMS].zero ? 33'b0 : (tr[SERIES_TERMS] >> tc[SERIES_TERMS].k);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (enable) begin
         ve_ff <= tv[SERIES_TERMS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e_ff <= e_in;
      end
   end

   assign valid_out = ve_ff;
   assign exp_value = e_ff;

endmodule

`default_nettype wire

FILE: design/erfe_divider.sv
// pipelined restoring divider: 21 quotient bits of (num << 30) / den plus overflow
`default_nettype none

module erfe_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        enable,
   input  wire logic                        valid_in,
   input  wire logic [erfe_pkg::NUM_W-1:0]  num_value,
   input  wire logic [erfe_pkg::DEN_W-1:0]  den_value,
   input  wire logic                        neg_in,
   output logic                             valid_out,
   output logic [erfe_pkg::DIV_BITS-1:0]    quo_value,
   output logic                             ovf_out,
   output logic                             neg_out
);
   import erfe_pkg::*;

   logic                valid_ff [DIV_STAGES];
   logic [REM_W-1:0]    rem_ff   [DIV_STAGES];
   logic [REM_W-1:0]    rem_in   [DIV_STAGES];
   logic [DEN_W-1:0]    den_ff   [DIV_STAGES];
   logic [DIV_BITS-1:0] quo_ff   [DIV_STAGES];
   logic [DIV_BITS-1:0] quo_in   [DIV_STAGES];
   logic                ovf_ff   [DIV_STAGES];
   logic                ovf_in;
   logic                neg_ff   [DIV_STAGES];
   logic [REM_W-1:0]    sub_val  [DIV_STAGES];

   // load stage and one quotient bit per later stage
   always_comb begin
      rem_in[0]  = REM_W'({num_value, 30'b0});
      quo_in[0]  = '0;
      sub_val[0] = REM_W'(den_value) << DIV_BITS;
      ovf_in     = (rem_in[0] >= sub_val[0]);
      for (int j = 1; j < DIV_STAGES; j++) begin
         sub_val[j] = REM_W'(den_ff[j-1]) << (DIV_BITS - j);
         rem_in[j]  = rem_ff[j-1];
         quo_in[j]  = quo_ff[j-1];
         if (!ovf_ff[j-1] && (rem_ff[j-1] >= sub_val[j])) begin
            rem_in[j]                = rem_ff[j-1] - sub_val[j];
            quo_in[j][DIV_BITS - j]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_STAGES; j++) valid_ff[j] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= valid_in;
         for (int j = 1; j < DIV_STAGES; j++) valid_ff[j] <= valid_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
         den_ff[0] <= den_value;
         ovf_ff[0] <= ovf_in;
         neg_ff[0] <= neg_in;
         for (int j = 1; j < DIV_STAGES; j++) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            den_ff[j] <= den_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   assign valid_out = valid_ff[DIV_STAGES-1];
   assign quo_value = quo_ff[DIV_STAGES-1];
   assign ovf_out   = ovf_ff[DIV_STAGES-1];
   assign neg_out   = neg_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: design/erf_approximation_exp_based_core.sv
// top level: erf(x) ~ 1 - (1 - exp(-1.98|x|)) exp(-x^2) / (B|x|), sign of x applied
//
//   channel | ports                          | payload
//   req     | req_valid / req_ready          | req_x_value   Q3.12 signed
//   rsp     | rsp_valid / rsp_ready          | rsp_erf_value Q1.14 signed
//
// one transaction per cycle while rsp is not stalled
// the path runs through the two 12-term exponential chains (26 stages) and the
// 22-stage restoring divider
// synchronous active-high reset clears all valid bits; payload registers are not reset
// a stall on rsp holds every stage; req_ready falls while the output is full and not taken
`default_nettype none

module erf_approximation_exp_based_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_x_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_erf_value
);
   import erfe_pkg::*;

   typedef struct packed {
      logic [15:0] a;
      logic        neg;
   } side_type;

   logic advance;

   logic        v1_ff, v2_ff, v3_ff;
   logic [15:0] a1_ff, a2_ff, a3_ff, a1_in;
   logic        n1_ff, n2_ff, n3_ff;
   logic [U_W-1:0] u1a_ff, u1b_ff, u2_ff, u1_in, u2_in;
   logic [30:0] asq_ff;
   logic [31:0] asq_full;
   logic [47:0] u1_prod;
   logic [61:0] u2_prod;

   side_type    side_ff [EXP_LATENCY];

   logic        e1_valid, e2_valid;
   logic [32:0] e1_value, e2_value;

   logic [32:0] d_value;
   logic [63:0] num_low;
   logic [64:0] num_prod;
   logic [47:0] den_full;
   logic        vn_ff, nn_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;

   logic                div_valid, div_ovf, div_neg;
   logic [DIV_BITS-1:0] div_quo;

   logic [20:0] m_value;
   logic [21:0] y_round;
   logic [15:0] y_value, y_sat;
   logic        out_valid_ff;
   logic [15:0] out_value_ff, out_value_in;

   // global pipeline enable
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;

   // magnitude of x and the exponent products
   always_comb begin
      a1_in    = req_x_value[15] ? (~req_x_value + 16'd1) : req_x_value;
      u1_prod  = a1_ff * A_LOG2E_Q30;
      u1_in    = U_W'(u1_prod >> 18);
      asq_full = a1_ff * a1_ff;
      u2_prod  = asq_ff * LOG2E_Q30;
      u2_in    = U_W'(u2_prod >> 30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a1_ff  <= a1_in;
         n1_ff  <= req_x_value[15];
         a2_ff  <= a1_ff;
         n2_ff  <= n1_ff;
         u1a_ff <= u1_in;
         asq_ff <= asq_full[30:0];
         a3_ff  <= a2_ff;
         n3_ff  <= n2_ff;
         u1b_ff <= u1a_ff;
         u2_ff  <= u2_in;
      end
   end

   // magnitude and sign ride alongside the exponential chains
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= '{a: a3_ff, neg: n3_ff};
         for (int i = 1; i < EXP_LATENCY; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   erfe_neg_exp u_exp_lin (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .valid_in  (v3_ff),
      .u_value   (u1b_ff),
      .valid_out (e1_valid),
      .exp_value (e1_value)
   );

   erfe_neg_exp u_exp_sq (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .valid_in  (v3_ff),
      .u_value   (u2_ff),
      .valid_out (e2_valid),
      .exp_value (e2_value)
   );

   // numerator (1 - E1) * E2 and denominator B * |x|
   always_comb begin
      d_value  = ONE_Q32 - e1_value;
      num_low  = d_value[31:0] * e2_value[31:0];
      if (d_value[32]) begin
         num_prod = {e2_value, 32'b0};
      end else if (e2_value[32]) begin
         num_prod = {d_value, 32'b0};
      end else begin
         num_prod = {1'b0, num_low};
      end
      den_full = side_ff[EXP_LATENCY-1].a * B_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
      end else if (advance) begin
         vn_ff <= e2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_prod[64:32];
         den_ff <= den_full[DEN_W-1:0];
         nn_ff  <= side_ff[EXP_LATENCY-1].neg;
      end
   end

   erfe_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .valid_in  (vn_ff),
      .num_value (num_ff),
      .den_value (den_ff),
      .neg_in    (nn_ff),
      .valid_out (div_valid),
      .quo_value (div_quo),
      .ovf_out   (div_ovf),
      .neg_out   (div_neg)
   );

   // 1 - q, round to Q1.14, saturate, apply sign
   always_comb begin
      m_value      = (div_ovf || (div_quo > ONE_Q20)) ? 21'b0 : (ONE_Q20 - div_quo);
      y_round      = {1'b0, m_value} + 22'd32;
      y_value      = y_round[21:6];
      y_sat        = (y_value > Y_MAX) ? Y_MAX : y_value;
      out_value_in = div_neg ? (~y_sat + 16'd1) : y_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_erf_value = out_value_ff;

   // both exponential chains stay in lockstep
   a_exp_lockstep: assert property (@(posedge clock) disable iff (reset)
      e1_valid == e2_valid)
      else $error("exponential chains out of step");

   // response magnitude never exceeds 1.0
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_erf_value) <= 16'sd16384 &&
                     $signed(rsp_erf_value) >= -16'sd16384))
      else $error("response out of range");

   // a divider overflow becomes a zero response
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && div_valid && div_ovf) |=> (rsp_valid && rsp_erf_value == 16'd0))
      else $error("overflowed quotient did not give zero");

   // a stall freezes the divider output
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(div_valid) && $stable(div_quo)))
      else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
